// ----- rtl/core/rcdb_pkg.sv -----
package rcdb_pkg;

	typedef enum logic [1:0] {
		OP_ENCODE  = 2'd0,
		OP_FLUSH   = 2'd1,
		OP_RESTART = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BIT,
		ST_SHIFT,
		ST_END
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] value;
		logic [5:0]  nbits;
	} item_t;

	typedef struct packed {
		logic [7:0]  head_byte;
		logic [7:0]  run_byte;
		logic [31:0] run_length;
		logic        last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load_enc;
		logic load_flush;
		logic restart;
		logic bit_step;
		logic shift_step;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_in_zero;
		logic renorm;
		logic cnt_last;
		logic cnt_zero;
		logic shift_blocked;
		logic hold_v;
		logic out_free;
	} sts_t;

	localparam logic [5:0]  MAX_BITS  = 6'd32;
	localparam logic [7:0]  BYTE_FF   = 8'hFF;
	localparam logic [31:0] RUN_SAT   = 32'hFFFF_FFFF;

endpackage

// ----- rtl/core/rcdb_ctrl.sv -----
module rcdb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic [1:0]    item_op,
	input  rcdb_pkg::sts_t sts,
	output logic          item_stall,
	output rcdb_pkg::cmd_t cmd
);
	import rcdb_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (op_t'(item_op))
						OP_ENCODE: if (!sts.cnt_in_zero) state_d = ST_BIT;
						OP_FLUSH:  state_d = ST_SHIFT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_BIT: begin
				if (sts.renorm) state_d = ST_SHIFT;
				else if (sts.cnt_last) state_d = ST_END;
			end
			ST_SHIFT: begin
				if (!sts.shift_blocked) state_d = sts.cnt_zero ? ST_END : ST_BIT;
			end
			ST_END: begin
				if (!sts.hold_v || sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					case (op_t'(item_op))
						OP_ENCODE:  cmd.load_enc   = !sts.cnt_in_zero;
						OP_FLUSH:   cmd.load_flush = 1'b1;
						OP_RESTART: cmd.restart    = 1'b1;
						default:    cmd            = '0;
					endcase
				end
			end
			ST_BIT:   cmd.bit_step   = 1'b1;
			ST_SHIFT: cmd.shift_step = !sts.shift_blocked;
			ST_END:   cmd.finish     = sts.hold_v && sts.out_free;
			default:  cmd            = '0;
		endcase
	end

endmodule

// ----- rtl/core/rcdb_dp.sv -----
module rcdb_dp #(
	parameter int PENDING_COUNT_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rcdb_pkg::item_t   item,
	input  rcdb_pkg::cmd_t    cmd,
	output rcdb_pkg::sts_t    sts,
	output logic              result_valid,
	input  logic              result_stall,
	output rcdb_pkg::result_t result
);
	import rcdb_pkg::*;

	logic [32:0] low_q;
	logic [31:0] range_q;
	logic [7:0]  cache_q;
	logic [PENDING_COUNT_BITS-1:0] pend_q;
	logic [31:0] val_q;
	logic [5:0]  cnt_q;
	result_t     hold_q;
	logic        hold_v_q;
	result_t     out_q;
	logic        out_v_q;

	logic [31:0] range_half;
	logic [4:0]  bit_idx;
	logic        cur_bit;
	logic        release_top;
	logic        carry;
	logic        out_free;
	logic        push;
	result_t     push_data;
	result_t     new_rec;
	logic [31:0] run_len;
	logic [5:0]  cnt_in;

	assign range_half  = {1'b0, range_q[31:1]};
	assign bit_idx     = 5'(cnt_q - 6'd1);
	assign cur_bit     = val_q[bit_idx];
	// top byte can still take a carry only while it reads 0xFF with no carry out
	assign release_top = low_q[32] || (low_q[31:24] != BYTE_FF);
	assign carry       = low_q[32];
	assign out_free    = !out_v_q || !result_stall;
	assign cnt_in      = (item.nbits > MAX_BITS) ? MAX_BITS : item.nbits;

	generate
		if (PENDING_COUNT_BITS > 32) begin : g_wide
			assign run_len = (pend_q[PENDING_COUNT_BITS-1:32] != '0) ? RUN_SAT : pend_q[31:0];
		end else begin : g_narrow
			assign run_len = 32'(pend_q);
		end
	endgenerate

	always_comb begin
		new_rec.head_byte  = cache_q + {7'd0, carry};
		new_rec.run_byte   = BYTE_FF + {7'd0, carry};
		new_rec.run_length = run_len;
		new_rec.last       = 1'b0;
	end

	assign push = (cmd.shift_step && release_top && hold_v_q) || cmd.finish;
	always_comb begin
		push_data      = hold_q;
		push_data.last = cmd.finish;
	end

	assign sts.cnt_in_zero   = (item.nbits == 6'd0);
	assign sts.renorm        = (range_q[31:25] == 7'd0);
	assign sts.cnt_last      = (cnt_q == 6'd1);
	assign sts.cnt_zero      = (cnt_q == 6'd0);
	assign sts.shift_blocked = release_top && hold_v_q && !out_free;
	assign sts.hold_v        = hold_v_q;
	assign sts.out_free      = out_free;

	// coder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '0;
			range_q <= '1;
			cache_q <= '0;
			pend_q  <= '0;
		end else if (cmd.restart) begin
			low_q   <= '0;
			range_q <= '1;
			cache_q <= '0;
			pend_q  <= '0;
		end else if (cmd.bit_step) begin
			if (cur_bit) low_q <= low_q + {1'b0, range_half};
			range_q <= sts.renorm ? {range_half[23:0], 8'd0} : range_half;
		end else if (cmd.shift_step) begin
			low_q <= {1'b0, low_q[23:0], 8'd0};
			if (release_top) begin
				cache_q <= low_q[31:24];
				pend_q  <= '0;
			end else if (pend_q != '1) begin
				pend_q <= pend_q + {{(PENDING_COUNT_BITS-1){1'b0}}, 1'b1};
			end
		end
	end

	// item bits and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_enc) begin
			cnt_q <= cnt_in;
		end else if (cmd.load_flush) begin
			cnt_q <= '0;
		end else if (cmd.bit_step) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_enc) val_q <= item.value;
	end

	// one result held back until we know whether it is the item's last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (cmd.shift_step && release_top) begin
			hold_v_q <= 1'b1;
		end else if (cmd.finish) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_step && release_top) hold_q <= new_rec;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (!result_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) out_q <= push_data;
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule

// ----- rtl/core/range_coder_direct_bits_encoder.sv -----
// Range encoder for equiprobable (direct) bits, with carry propagation.
// Item channel (item_valid / item_stall / item): one beat per command.
//   operation ENCODE codes nbits bits of value MSB first (counts above
//   32 clamp to 32, zero codes nothing); FLUSH runs one shift-low step;
//   RESTART returns the coder to its reset state; the unused code is dropped.
// Result channel (result_valid / result_stall / result): one beat per
//   released byte group: head_byte, then run_length copies of run_byte.
//   last marks the final beat an item produces; items may produce none.
// Sequence: an accept cycle, then for ENCODE one bit step per coded bit,
//   with a shift-low step after each bit step that renormalises the range,
//   and a closing cycle; FLUSH runs one shift-low step and the closing
//   cycle; RESTART and the unused code complete in the accept cycle. A new
//   item is taken only once the previous one has handed its results to the
//   output register. A result waits in a holding register until the next
//   released group or the closing cycle settles its last flag, and shows on
//   the result channel the cycle after that step.
// Receiver stall: the output register holds its beat; a further result
//   then blocks the shift-low step or the closing cycle until it frees up.
// Reset: arst_n clears low, cached byte and pending count, sets range to all
//   ones, and drops any result in flight.
module range_coder_direct_bits_encoder #(
	parameter int PENDING_COUNT_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  rcdb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output rcdb_pkg::result_t result
);
	import rcdb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: accepts items, walks bits and shift-low steps
	rcdb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.operation),
		.sts        (sts),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	// low/range arithmetic, carry cache, held result and output register
	rcdb_dp #(
		.PENDING_COUNT_BITS (PENDING_COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
